// ----- src/ldtp_pkg.sv -----
// Shared types, codes and constants for the LED dimmer timeout pulse controller.
`timescale 1ns / 1ps

package ldtp_pkg;

    // command codes carried in op
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_TOUCH   = 3'd1,
        OP_LEVEL   = 3'd2,
        OP_BRIGHT  = 3'd3,
        OP_PULSE   = 3'd4,
        OP_KEEP    = 3'd5,
        OP_SUSPEND = 3'd6,
        OP_RESUME  = 3'd7
    } op_t;

    // register indexes on the APB port
    localparam logic [2:0] REG_MAX_LEVEL    = 3'd0;
    localparam logic [2:0] REG_TIMEOUT      = 3'd1;
    localparam logic [2:0] REG_BOOT_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_PAUSE_MS     = 3'd3;
    localparam logic [2:0] REG_INIT_LEVEL   = 3'd4;
    localparam logic [2:0] REG_START_TICKS  = 3'd5;

    localparam int ADDR_W = 5;

    // register reset values
    localparam logic [7:0]  MAX_LEVEL_RST    = 8'd100;
    localparam logic [15:0] TIMEOUT_RST      = 16'd10000;
    localparam logic [15:0] BOOT_TIMEOUT_RST = 16'd30000;
    localparam logic [15:0] PAUSE_MS_RST     = 16'd0;
    localparam logic [7:0]  INIT_LEVEL_RST   = 8'd20;
    localparam logic [9:0]  START_TICKS_RST  = 10'd100;

    // fixed arithmetic constants
    localparam logic [7:0] MIN_PULSE_LEVEL = 8'd10;
    localparam logic [9:0] BRIGHT_DIVISOR  = 10'd255;
    localparam logic [9:0] MS_PER_SEC      = 10'd1000;

    // shared divider geometry
    localparam int DVD_W     = 21;
    localparam int DVS_W     = 10;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [7:0]  max_level;
        logic [15:0] timeout_ticks;
        logic [15:0] pulse_pause_ms;
        logic [9:0]  pulse_start_ticks;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- src/led_dimmer_timeout_pulse_controller.sv -----
// Top level of the LED dimmer timeout pulse controller.
// One item is a 1 ms tick or a command; each yields one result carrying the
// driven level, the pulsing flag and the auto-off timer flag. in_ready is low
// from the transfer of an item until its result is loaded into the output
// register. Brightness writes, pulse starts and ramp-ending ticks run the
// shared 21-step restoring divider. A result waiting in the output register
// does not block the next item; an item finishing while that register is
// still full holds until the earlier result is taken. The user must write
// registers through the APB port only while the block is idle; this is not
// enforced. Writes (not boot timeout or init level) act on the next item.
`timescale 1ns / 1ps

module led_dimmer_timeout_pulse_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ldtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  op,
    input  logic [15:0]                 value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  drive_level,
    output logic                        pulsing,
    output logic                        timer_running
);

    ldtp_pkg::cfg_t     cfg;
    ldtp_pkg::div_req_t div_req;
    ldtp_pkg::div_rsp_t div_rsp;

    ldtp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ldtp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ldtp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_level   (drive_level),
        .pulsing       (pulsing),
        .timer_running (timer_running),
        .div_req       (div_req),
        .div_rsp       (div_rsp)
    );

endmodule

// ----- src/ldtp_cfg.sv -----
// APB configuration register file.
`timescale 1ns / 1ps

module ldtp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ldtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ldtp_pkg::cfg_t              cfg
);

    logic [7:0]  max_level_reg;
    logic [15:0] timeout_reg;
    logic [15:0] boot_timeout_reg;
    logic [15:0] pause_ms_reg;
    logic [7:0]  init_level_reg;
    logic [9:0]  start_ticks_reg;
    logic [2:0]  index;
    logic        wr_en;

    assign index  = paddr[ldtp_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg    <= ldtp_pkg::MAX_LEVEL_RST;
            timeout_reg      <= ldtp_pkg::TIMEOUT_RST;
            boot_timeout_reg <= ldtp_pkg::BOOT_TIMEOUT_RST;
            pause_ms_reg     <= ldtp_pkg::PAUSE_MS_RST;
            init_level_reg   <= ldtp_pkg::INIT_LEVEL_RST;
            start_ticks_reg  <= ldtp_pkg::START_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                ldtp_pkg::REG_MAX_LEVEL:    max_level_reg    <= pwdata[7:0];
                ldtp_pkg::REG_TIMEOUT:      timeout_reg      <= pwdata[15:0];
                ldtp_pkg::REG_BOOT_TIMEOUT: boot_timeout_reg <= pwdata[15:0];
                ldtp_pkg::REG_PAUSE_MS:     pause_ms_reg     <= pwdata[15:0];
                ldtp_pkg::REG_INIT_LEVEL:   init_level_reg   <= pwdata[7:0];
                ldtp_pkg::REG_START_TICKS:  start_ticks_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            ldtp_pkg::REG_MAX_LEVEL:    prdata = {24'd0, max_level_reg};
            ldtp_pkg::REG_TIMEOUT:      prdata = {16'd0, timeout_reg};
            ldtp_pkg::REG_BOOT_TIMEOUT: prdata = {16'd0, boot_timeout_reg};
            ldtp_pkg::REG_PAUSE_MS:     prdata = {16'd0, pause_ms_reg};
            ldtp_pkg::REG_INIT_LEVEL:   prdata = {24'd0, init_level_reg};
            ldtp_pkg::REG_START_TICKS:  prdata = {22'd0, start_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.max_level         = max_level_reg;
    assign cfg.timeout_ticks     = timeout_reg;
    assign cfg.pulse_pause_ms    = pause_ms_reg;
    assign cfg.pulse_start_ticks = start_ticks_reg;

endmodule

// ----- src/ldtp_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ldtp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ldtp_pkg::div_req_t req,
    output ldtp_pkg::div_rsp_t rsp
);

    localparam int DVD_W = ldtp_pkg::DVD_W;
    localparam int DVS_W = ldtp_pkg::DVS_W;
    localparam int CNT_W = ldtp_pkg::DIV_CNT_W;

    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (req.start)
        begin
            count_reg <= CNT_W'(ldtp_pkg::DIV_STEPS);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (count_reg == CNT_W'(1));
            if (count_reg != '0)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (count_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- src/ldtp_core.sv -----
// Command sequencer: LED level, auto-off timer, keep-on/awake flags and pulse phases.
`timescale 1ns / 1ps

module ldtp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  ldtp_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [15:0]        value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         drive_level,
    output logic               pulsing,
    output logic               timer_running,
    output ldtp_pkg::div_req_t div_req,
    input  ldtp_pkg::div_rsp_t div_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_RAMP, PH_PAUSE} phase_t;
    typedef enum logic [1:0] {DV_BRIGHT, DV_STEP, DV_PAUSE_CFG, DV_PAUSE_DEF} purpose_t;

    state_t      state_reg, state_next;
    purpose_t    purpose_reg, purpose_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  level_reg, level_next;
    logic [7:0]  drive_reg, drive_next;
    logic [7:0]  peak_reg, peak_next;
    logic        keep_on_reg, keep_on_next;
    logic        awake_reg, awake_next;
    logic        timer_active_reg, timer_active_next;
    logic [15:0] timer_count_reg, timer_count_next;
    logic [15:0] step_ms_reg, step_ms_next;
    logic [16:0] phase_count_reg, phase_count_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_drive_reg, out_drive_next;
    logic        out_pulsing_reg, out_pulsing_next;
    logic        out_timer_reg, out_timer_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign drive_level   = out_drive_reg;
    assign pulsing       = out_pulsing_reg;
    assign timer_running = out_timer_reg;

    always_comb
    begin
        logic [16:0] pc_dec;
        logic [7:0]  lvl;
        logic [15:0] diff;

        state_next        = state_reg;
        purpose_next      = purpose_reg;
        phase_next        = phase_reg;
        level_next        = level_reg;
        drive_next        = drive_reg;
        peak_next         = peak_reg;
        keep_on_next      = keep_on_reg;
        awake_next        = awake_reg;
        timer_active_next = timer_active_reg;
        timer_count_next  = timer_count_reg;
        step_ms_next      = step_ms_reg;
        phase_count_next  = phase_count_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_drive_next    = out_drive_reg;
        out_pulsing_next  = out_pulsing_reg;
        out_timer_next    = out_timer_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = '0;
        div_req.divisor   = '0;
        pc_dec            = (phase_count_reg != 17'd0) ? phase_count_reg - 17'd1 : 17'd0;
        lvl               = (peak_reg != 8'd0) ? peak_reg : level_reg;
        if (lvl < ldtp_pkg::MIN_PULSE_LEVEL)
        begin
            lvl = ldtp_pkg::MIN_PULSE_LEVEL;
        end
        diff = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OUT;
                    case (op)
                        ldtp_pkg::OP_TICK:
                        begin
                            // timer first, then the pulse sequencer
                            if (timer_active_reg)
                            begin
                                if (timer_count_reg > 16'd1)
                                begin
                                    timer_count_next = timer_count_reg - 16'd1;
                                end
                                else
                                begin
                                    timer_active_next = 1'b0;
                                    timer_count_next  = '0;
                                    if (peak_reg == 8'd0 && !keep_on_reg)
                                    begin
                                        drive_next = '0;
                                    end
                                end
                            end
                            if (phase_reg != PH_IDLE)
                            begin
                                if (pc_dec != 17'd0)
                                begin
                                    phase_count_next = pc_dec;
                                end
                                else if (phase_reg == PH_PAUSE)
                                begin
                                    phase_next       = PH_WAIT;
                                    phase_count_next = {7'd0, cfg.pulse_start_ticks};
                                end
                                else
                                begin
                                    phase_next = PH_RAMP;
                                    if (level_reg != 8'd0)
                                    begin
                                        level_next       = level_reg - 8'd1;
                                        drive_next       = level_reg - 8'd1;
                                        phase_count_next = {1'b0, step_ms_reg};
                                    end
                                    else
                                    begin
                                        // ramp done: restore peak, pause length is
                                        // whole seconds worth of ms
                                        level_next      = peak_reg;
                                        phase_next      = PH_PAUSE;
                                        state_next      = S_DIV;
                                        div_req.start   = 1'b1;
                                        div_req.divisor = ldtp_pkg::MS_PER_SEC;
                                        if (cfg.pulse_pause_ms != 16'd0)
                                        begin
                                            purpose_next     = DV_PAUSE_CFG;
                                            div_req.dividend = {5'd0, cfg.pulse_pause_ms};
                                        end
                                        else
                                        begin
                                            purpose_next     = DV_PAUSE_DEF;
                                            div_req.dividend = {5'd0, step_ms_reg};
                                        end
                                    end
                                end
                            end
                        end
                        ldtp_pkg::OP_TOUCH:
                        begin
                            if (awake_reg)
                            begin
                                if (value != 16'd0)
                                begin
                                    timer_active_next = 1'b1;
                                    timer_count_next  = cfg.timeout_ticks;
                                    drive_next        = level_reg;
                                end
                                else
                                begin
                                    timer_active_next = 1'b0;
                                    timer_count_next  = '0;
                                    if (!keep_on_reg)
                                    begin
                                        drive_next = '0;
                                    end
                                end
                            end
                        end
                        ldtp_pkg::OP_LEVEL:
                        begin
                            lvl = (value > {8'd0, cfg.max_level}) ? cfg.max_level : value[7:0];
                            level_next        = lvl;
                            drive_next        = lvl;
                            timer_active_next = 1'b0;
                            timer_count_next  = '0;
                        end
                        ldtp_pkg::OP_BRIGHT:
                        begin
                            state_next       = S_DIV;
                            purpose_next     = DV_BRIGHT;
                            div_req.start    = 1'b1;
                            div_req.dividend = {1'b0, value, 4'd0} + {3'd0, value, 2'd0};
                            div_req.divisor  = ldtp_pkg::BRIGHT_DIVISOR;
                        end
                        ldtp_pkg::OP_PULSE:
                        begin
                            if (value == 16'd0)
                            begin
                                if (peak_reg != 8'd0)
                                begin
                                    level_next        = peak_reg;
                                    peak_next         = '0;
                                    phase_next        = PH_IDLE;
                                    phase_count_next  = '0;
                                    timer_active_next = 1'b0;
                                    timer_count_next  = '0;
                                    if (!keep_on_reg)
                                    begin
                                        drive_next = '0;
                                    end
                                end
                            end
                            else
                            begin
                                level_next       = lvl;
                                peak_next        = lvl;
                                phase_next       = PH_WAIT;
                                phase_count_next = {7'd0, cfg.pulse_start_ticks};
                                state_next       = S_DIV;
                                purpose_next     = DV_STEP;
                                div_req.start    = 1'b1;
                                div_req.dividend = {5'd0, value};
                                div_req.divisor  = {2'd0, lvl};
                            end
                        end
                        ldtp_pkg::OP_KEEP:
                        begin
                            keep_on_next = (value != 16'd0);
                            if (value != 16'd0)
                            begin
                                timer_active_next = 1'b1;
                                timer_count_next  = cfg.timeout_ticks;
                                drive_next        = level_reg;
                            end
                            else
                            begin
                                timer_active_next = 1'b0;
                                timer_count_next  = '0;
                                drive_next        = '0;
                            end
                        end
                        ldtp_pkg::OP_SUSPEND:
                        begin
                            awake_next = 1'b0;
                            if (!keep_on_reg && peak_reg == 8'd0)
                            begin
                                timer_active_next = 1'b0;
                                timer_count_next  = '0;
                                drive_next        = '0;
                            end
                        end
                        default:
                        begin
                            awake_next = 1'b1;
                            if (!keep_on_reg && peak_reg == 8'd0)
                            begin
                                timer_active_next = 1'b1;
                                timer_count_next  = cfg.timeout_ticks;
                                drive_next        = level_reg;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                    unique case (purpose_reg)
                        DV_BRIGHT:
                        begin
                            level_next = (div_rsp.quotient > {13'd0, cfg.max_level}) ?
                                         cfg.max_level : div_rsp.quotient[7:0];
                        end
                        DV_STEP:
                        begin
                            step_ms_next = div_rsp.quotient[15:0];
                        end
                        DV_PAUSE_CFG:
                        begin
                            phase_count_next = {1'b0, cfg.pulse_pause_ms}
                                             - {7'd0, div_rsp.remainder};
                        end
                        default:
                        begin
                            // four seconds of pause per whole second of step
                            diff             = step_ms_reg - {6'd0, div_rsp.remainder};
                            phase_count_next = {diff[14:0], 2'b00};
                        end
                    endcase
                end
            end
            default:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_drive_next   = drive_reg;
                    out_pulsing_next = (peak_reg != 8'd0);
                    out_timer_next   = timer_active_reg;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            purpose_reg      <= DV_BRIGHT;
            phase_reg        <= PH_IDLE;
            level_reg        <= ldtp_pkg::INIT_LEVEL_RST;
            drive_reg        <= ldtp_pkg::INIT_LEVEL_RST;
            peak_reg         <= '0;
            keep_on_reg      <= 1'b0;
            awake_reg        <= 1'b1;
            timer_active_reg <= 1'b1;
            timer_count_reg  <= ldtp_pkg::BOOT_TIMEOUT_RST;
            step_ms_reg      <= '0;
            phase_count_reg  <= '0;
            out_valid_reg    <= 1'b0;
            out_drive_reg    <= '0;
            out_pulsing_reg  <= 1'b0;
            out_timer_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            purpose_reg      <= purpose_next;
            phase_reg        <= phase_next;
            level_reg        <= level_next;
            drive_reg        <= drive_next;
            peak_reg         <= peak_next;
            keep_on_reg      <= keep_on_next;
            awake_reg        <= awake_next;
            timer_active_reg <= timer_active_next;
            timer_count_reg  <= timer_count_next;
            step_ms_reg      <= step_ms_next;
            phase_count_reg  <= phase_count_next;
            out_valid_reg    <= out_valid_next;
            out_drive_reg    <= out_drive_next;
            out_pulsing_reg  <= out_pulsing_next;
            out_timer_reg    <= out_timer_next;
        end
    end

endmodule

// ----- src/ldtp_checker.sv -----
// Port-level checker for the LED dimmer timeout pulse controller, with its bind.
`timescale 1ns / 1ps

module ldtp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       psel,
    input logic       penable,
    input logic       pready,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] drive_level,
    input logic       pulsing,
    input logic       timer_running
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_level)
            && $stable(pulsing) && $stable(timer_running))
        else $error("result changed while stalled");

    // one item in flight: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a new result only appears after the block was busy
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item");

    // config access never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("config access stalled");

endmodule

bind led_dimmer_timeout_pulse_controller ldtp_checker u_ldtp_checker (.*);
